[rtl/core/bdic_pkg.sv]
`default_nettype none

package bdic_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned MARGIN_W   = 12;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;

  // Configuration port
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_HIGH_MARGIN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_MARGIN   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAPTURE_MODE = 2'd2;

  localparam logic [MARGIN_W-1:0] HIGH_MARGIN_RST  = 12'd9;
  localparam logic [MARGIN_W-1:0] LOW_MARGIN_RST   = 12'd9;
  localparam logic                CAPTURE_MODE_RST = 1'b1;

  // Queue between classifier and dispense control
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_WAITING    = 2'd0,
    ST_DISPENSING = 2'd1,
    ST_DONE       = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] ch0_sample;
    logic [SAMPLE_W-1:0] ch1_sample;
    logic [SAMPLE_W-1:0] ch2_sample;
    logic [SAMPLE_W-1:0] ch3_sample;
    logic [COUNT_W-1:0]  target_count;
  } item_t;

  typedef struct packed {
    logic                mean_ready;
    logic                detected;
    logic [CH_W-1:0]     detect_channel;
    logic                detect_high;
    logic                ack;
    logic                motor_run;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  items_counted;
  } result_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] high_margin;
    logic [MARGIN_W-1:0] low_margin;
    logic                capture_mode;
  } cfg_t;

  // Classified transaction handed from the front to the back
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] target;
    logic               mean_ready;
    logic               detected;
    logic [CH_W-1:0]    detect_channel;
    logic               detect_high;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/bdic_stream_if.sv]
`default_nettype none

interface bdic_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/bdic_cfg_regs.sv]
`default_nettype none

module bdic_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bdic_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bdic_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bdic_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output bdic_pkg::cfg_t                     cfg_o
);

  logic [bdic_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;
  bdic_pkg::cfg_t                 cfg_q;

  assign idx    = paddr[bdic_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_margin  <= bdic_pkg::HIGH_MARGIN_RST;
      cfg_q.low_margin   <= bdic_pkg::LOW_MARGIN_RST;
      cfg_q.capture_mode <= bdic_pkg::CAPTURE_MODE_RST;
    end else if (wr_en) begin
      unique case (idx)
        bdic_pkg::REG_HIGH_MARGIN:  cfg_q.high_margin  <= pwdata[bdic_pkg::MARGIN_W-1:0];
        bdic_pkg::REG_LOW_MARGIN:   cfg_q.low_margin   <= pwdata[bdic_pkg::MARGIN_W-1:0];
        bdic_pkg::REG_CAPTURE_MODE: cfg_q.capture_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      bdic_pkg::REG_HIGH_MARGIN:  prdata[bdic_pkg::MARGIN_W-1:0] = cfg_q.high_margin;
      bdic_pkg::REG_LOW_MARGIN:   prdata[bdic_pkg::MARGIN_W-1:0] = cfg_q.low_margin;
      bdic_pkg::REG_CAPTURE_MODE: prdata[0] = cfg_q.capture_mode;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/bdic_front.sv]
`default_nettype none

module bdic_front #(
  parameter int unsigned FRAMES_PER_MEAN = 20,
  parameter int unsigned SAMPLE_BITS     = 12
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bdic_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire bdic_pkg::item_t in_item_i,
  output logic                 push_o,
  input  wire logic            full_i,
  output bdic_pkg::entry_t     entry_o
);

  localparam int unsigned EFF_W  = (SAMPLE_BITS < bdic_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                       : bdic_pkg::SAMPLE_W;
  localparam int unsigned LOG_N  = $clog2(FRAMES_PER_MEAN);
  localparam int unsigned SUM_W  = EFF_W + LOG_N;
  localparam int unsigned CNT_W  = (LOG_N > 0) ? LOG_N : 1;
  localparam int unsigned SHIFT  = SUM_W + LOG_N;
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  localparam int unsigned CMP_W  = ((EFF_W > bdic_pkg::MARGIN_W) ? EFF_W
                                                                  : bdic_pkg::MARGIN_W) + 1;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(FRAMES_PER_MEAN) - 64'd1) / 64'(FRAMES_PER_MEAN));
  localparam logic [CNT_W-1:0] LAST_FRAME = CNT_W'(FRAMES_PER_MEAN - 1);
  localparam int unsigned NCH = bdic_pkg::NUM_CH;

  logic                advance;
  logic                accept;
  logic                is_sample;
  logic                last_frame;
  logic [EFF_W-1:0]    samp      [NCH];
  logic [SUM_W-1:0]    sum_next  [NCH];

  logic [SUM_W-1:0]    sums_q    [NCH];
  logic [CNT_W-1:0]    cnt_q;

  logic                s1_valid_q;
  logic                s1_mean_q;
  logic [bdic_pkg::KIND_W-1:0]  s1_kind_q;
  logic [bdic_pkg::COUNT_W-1:0] s1_target_q;
  logic [SUM_W-1:0]    s1_sum_q  [NCH];

  logic [PROD_W-1:0]   prod      [NCH];

  logic                s2_valid_q;
  logic                s2_mean_q;
  logic [bdic_pkg::KIND_W-1:0]  s2_kind_q;
  logic [bdic_pkg::COUNT_W-1:0] s2_target_q;
  logic [EFF_W-1:0]    s2_avg_q  [NCH];

  logic [EFF_W-1:0]    refs_q    [NCH];
  logic [NCH-1:0]      above;
  logic [NCH-1:0]      below;

  // Hold the whole pipe while the last stage cannot hand over
  assign advance    = !s2_valid_q || !full_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;
  assign is_sample  = in_item_i.kind == bdic_pkg::KIND_SAMPLE;
  assign last_frame = cnt_q == LAST_FRAME;

  assign samp[0] = in_item_i.ch0_sample[EFF_W-1:0];
  assign samp[1] = in_item_i.ch1_sample[EFF_W-1:0];
  assign samp[2] = in_item_i.ch2_sample[EFF_W-1:0];
  assign samp[3] = in_item_i.ch3_sample[EFF_W-1:0];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_next[c] = sums_q[c] + SUM_W'(samp[c]);
    end
  end

  // Accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int c = 0; c < NCH; c++) begin
        sums_q[c] <= '0;
      end
    end else if (accept && is_sample) begin
      if (last_frame) begin
        cnt_q <= '0;
        for (int c = 0; c < NCH; c++) begin
          sums_q[c] <= '0;
        end
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        for (int c = 0; c < NCH; c++) begin
          sums_q[c] <= sum_next[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mean_q   <= is_sample && last_frame;
      s1_kind_q   <= in_item_i.kind;
      s1_target_q <= in_item_i.target_count;
      for (int c = 0; c < NCH; c++) begin
        s1_sum_q[c] <= sum_next[c];
      end
    end
  end

  // Divide by the frame count: reciprocal multiply, exact over the sum range
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] = PROD_W'(s1_sum_q[c]) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_mean_q   <= s1_mean_q;
      s2_kind_q   <= s1_kind_q;
      s2_target_q <= s1_target_q;
      for (int c = 0; c < NCH; c++) begin
        s2_avg_q[c] <= prod[c][SHIFT +: EFF_W];
      end
    end
  end

  // Window compares; channel 3 uses the high margin on its low side too
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      above[c] = CMP_W'(s2_avg_q[c]) > (CMP_W'(refs_q[c]) + CMP_W'(cfg_i.high_margin));
      below[c] = (CMP_W'(s2_avg_q[c]) +
                  CMP_W'((c == NCH - 1) ? cfg_i.high_margin : cfg_i.low_margin))
                 < CMP_W'(refs_q[c]);
    end
  end

  always_comb begin
    entry_o                = '0;
    entry_o.kind           = s2_kind_q;
    entry_o.target         = s2_target_q;
    entry_o.mean_ready     = s2_mean_q;
    if (s2_mean_q && !cfg_i.capture_mode) begin
      for (int c = NCH - 1; c >= 0; c--) begin
        if (above[c] || below[c]) begin
          entry_o.detected       = 1'b1;
          entry_o.detect_channel = bdic_pkg::CH_W'(c);
          entry_o.detect_high    = above[c];
        end
      end
    end
  end

  assign push_o = s2_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        refs_q[c] <= '0;
      end
    end else if (push_o && s2_mean_q && cfg_i.capture_mode) begin
      for (int c = 0; c < NCH; c++) begin
        refs_q[c] <= s2_avg_q[c];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/bdic_queue.sv]
`default_nettype none

module bdic_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bdic_pkg::entry_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output bdic_pkg::entry_t      data_o
);

  localparam int unsigned DEPTH = bdic_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  bdic_pkg::entry_t   slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [LVL_W-1:0]   level_q;

  assign full_o  = level_q == LVL_W'(DEPTH);
  assign empty_o = level_q == '0;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + LVL_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bdic_back.sv]
`default_nettype none

module bdic_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire bdic_pkg::entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bdic_pkg::result_t     out_o
);

  bdic_pkg::status_e             status_q, status_d;
  logic [bdic_pkg::COUNT_W-1:0]  count_q, count_d, count_inc;
  logic [bdic_pkg::COUNT_W-1:0]  target_q, target_d;
  logic                          motor_q, motor_d;
  logic                          ack;
  logic                          counting;
  logic                          out_valid_q;
  bdic_pkg::result_t             out_q;

  assign pop_o     = !empty_i && (!out_valid_q || out_ready_i);
  assign count_inc = count_q + bdic_pkg::COUNT_W'(1);
  assign counting  = entry_i.detected && (status_q == bdic_pkg::ST_DISPENSING);

  // Next state
  always_comb begin
    status_d = status_q;
    unique case (entry_i.kind)
      bdic_pkg::KIND_SAMPLE: begin
        if (counting && (count_inc == target_q)) begin
          status_d = bdic_pkg::ST_DONE;
        end
      end
      bdic_pkg::KIND_START: begin
        if (status_q != bdic_pkg::ST_DISPENSING) begin
          status_d = bdic_pkg::ST_DISPENSING;
        end
      end
      default: ;
    endcase
  end

  // Datapath and handshake outputs
  always_comb begin
    count_d  = count_q;
    target_d = target_q;
    motor_d  = motor_q;
    ack      = 1'b0;
    unique case (entry_i.kind)
      bdic_pkg::KIND_SAMPLE: begin
        if (counting) begin
          count_d = count_inc;
          motor_d = count_inc != target_q;
        end
      end
      bdic_pkg::KIND_START: begin
        if (status_q != bdic_pkg::ST_DISPENSING) begin
          count_d  = '0;
          target_d = entry_i.target;
          motor_d  = 1'b1;
          ack      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= bdic_pkg::ST_WAITING;
      count_q     <= '0;
      target_q    <= '0;
      motor_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        status_q <= status_d;
        count_q  <= count_d;
        target_q <= target_d;
        motor_q  <= motor_d;
      end
      out_valid_q <= pop_o || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.mean_ready     <= entry_i.mean_ready;
      out_q.detected       <= entry_i.detected;
      out_q.detect_channel <= entry_i.detect_channel;
      out_q.detect_high    <= entry_i.detect_high;
      out_q.ack            <= ack;
      out_q.motor_run      <= motor_d;
      out_q.status         <= status_d;
      out_q.items_counted  <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

[rtl/core/baseline_deviation_item_counter.sv]
// Path: a transaction accepted by the front passes two classifier stages, one queue slot
//   and the output register before its result shows.
// Throughput: one transaction per cycle through the accumulate and the four-entry queue;
//   the front stalls only when that queue is full.
// Reset (rst_ni, asynchronous, active low) clears sums, references, queue and dispense
//   state at once and loads the margins with 9 and capture mode with 1.
`default_nettype none

module baseline_deviation_item_counter #(
  parameter int unsigned FRAMES_PER_MEAN = 20,
  parameter int unsigned SAMPLE_BITS     = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  bdic_stream_if.sink                       item_i,
  bdic_stream_if.source                     result_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bdic_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bdic_pkg::PDATA_W-1:0] pwdata,
  output logic      [bdic_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  bdic_pkg::cfg_t    cfg;
  bdic_pkg::item_t   item;
  bdic_pkg::entry_t  push_entry;
  bdic_pkg::entry_t  pop_entry;
  bdic_pkg::result_t result;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  logic              item_ready;
  logic              res_valid;

  // Register file: user writes margins, capture mode only while idle; not enforced
  bdic_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item          = item_i.payload;
  assign item_i.ready  = item_ready;

  // Front: accumulate the four channels, form the means every frame block,
  // compare against the references or capture new ones, and classify each transaction
  bdic_front #(
    .FRAMES_PER_MEAN (FRAMES_PER_MEAN),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_ready),
    .in_item_i  (item),
    .push_o     (push),
    .full_i     (q_full),
    .entry_o    (push_entry)
  );

  // Queue: decouples classification from the dispense control so that a
  // stalled result does not stop sample intake straight away
  bdic_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_entry)
  );

  // Back: dispense state, item count, motor drive and the output register
  bdic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (res_valid),
    .out_ready_i (result_o.ready),
    .out_o       (result)
  );

  assign result_o.valid   = res_valid;
  assign result_o.payload = result;

endmodule

`default_nettype wire

[rtl/core/bdic_checker.sv]
`default_nettype none

module bdic_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire logic              res_ready_i,
  input  wire bdic_pkg::result_t res_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("result changed while stalled");

  // A detection only comes with a completed set of means
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.detected |-> res_i.mean_ready)
    else $error("detection without new means");

  // Motor runs exactly while dispensing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_i.motor_run == (res_i.status == bdic_pkg::ST_DISPENSING))
    else $error("motor drive disagrees with status");

  // An accepted start opens a fresh run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.ack |->
      res_i.status == bdic_pkg::ST_DISPENSING && res_i.items_counted == '0)
    else $error("accepted start did not open a fresh run");

endmodule

bind baseline_deviation_item_counter bdic_checker u_bdic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_i       (result_o.payload)
);

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
  import bdic_pkg::*;

  localparam int unsigned FRAMES_PER_MEAN = 20;
  localparam int unsigned CYCLE_LIMIT     = 500_000;
  localparam int unsigned PHASE_ITEMS     = 100;
  localparam int unsigned REPORT_CAP      = 40;

  // Kind code that the block must treat like a status query
  localparam logic [KIND_W-1:0]   KIND_RESERVED = 2'd3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 12'hFFF;
  localparam logic [COUNT_W-1:0]  TARGET_MAX    = 8'hFF;

  // Back-pressure patterns of the result sink
  localparam int unsigned SINK_FREE   = 0;
  localparam int unsigned SINK_COIN   = 1;
  localparam int unsigned SINK_SPARSE = 2;
  localparam int unsigned SINK_BURSTY = 3;

  // Baseline placement for a phase
  localparam int unsigned LVL_ANY   = 0;
  localparam int unsigned LVL_FLOOR = 1;
  localparam int unsigned LVL_CEIL  = 2;
  localparam int unsigned LVL_MIXED = 3;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  bdic_stream_if #(.payload_t(item_t))   item_if ();
  bdic_stream_if #(.payload_t(result_t)) result_if ();

  baseline_deviation_item_counter #(
    .FRAMES_PER_MEAN(FRAMES_PER_MEAN),
    .SAMPLE_BITS    (SAMPLE_W)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Dispense predictor: own copy of the block's state and configuration.
  // ---------------------------------------------------------------------------
  logic [16:0]          acc_sum [NUM_CH];
  logic [4:0]           acc_frames;
  logic [SAMPLE_W-1:0]  mean_ref [NUM_CH];
  status_e              disp_st;
  logic [COUNT_W-1:0]   item_cnt;
  logic [COUNT_W-1:0]   item_goal;
  logic                 motor_drive;

  logic [MARGIN_W-1:0]  cfg_hi;
  logic [MARGIN_W-1:0]  cfg_lo;
  logic                 cfg_capture;

  // Results still owed by the block, oldest first
  result_t pending_results [$];

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatch_cnt;
  int unsigned means_seen;
  int unsigned detects_seen;
  int unsigned starts_refused;
  int unsigned cycle_cnt;

  // Stimulus shaping: per-channel baseline and the offset applied to the
  // current averaging window
  int          stim_level  [NUM_CH];
  int          stim_offset [NUM_CH];
  bit          soak_on;
  int unsigned burst_left;

  // Advance the predictor by one transaction and return what the block owes.
  function automatic result_t next_dispense_result(input item_t it);
    result_t             r;
    int                  mean [NUM_CH];
    int                  fall;
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    r      = '0;
    smp[0] = it.ch0_sample;
    smp[1] = it.ch1_sample;
    smp[2] = it.ch2_sample;
    smp[3] = it.ch3_sample;
    case (it.kind)
      KIND_SAMPLE: begin
        for (int c = 0; c < NUM_CH; c++) acc_sum[c] = acc_sum[c] + smp[c];
        acc_frames = acc_frames + 5'd1;
        if (acc_frames >= FRAMES_PER_MEAN) begin
          r.mean_ready = 1'b1;
          means_seen++;
          for (int c = 0; c < NUM_CH; c++) begin
            mean[c]    = int'(acc_sum[c] / FRAMES_PER_MEAN);
            acc_sum[c] = '0;
          end
          acc_frames = '0;
          if (cfg_capture) begin
            for (int c = 0; c < NUM_CH; c++) mean_ref[c] = 12'(mean[c]);
          end else begin
            // Scan channels in order, high before low; the window is signed and
            // channel 3 uses the high margin on its low side too.
            for (int c = 0; c < NUM_CH && !r.detected; c++) begin
              fall = (c == 3) ? int'(cfg_hi) : int'(cfg_lo);
              if (mean[c] > int'(mean_ref[c]) + int'(cfg_hi)) begin
                r.detected       = 1'b1;
                r.detect_channel = CH_W'(c);
                r.detect_high    = 1'b1;
              end else if (mean[c] < int'(mean_ref[c]) - fall) begin
                r.detected       = 1'b1;
                r.detect_channel = CH_W'(c);
                r.detect_high    = 1'b0;
              end
            end
            if (r.detected) detects_seen++;
            if (r.detected && disp_st == ST_DISPENSING) begin
              item_cnt = item_cnt + 8'd1;
              if (item_cnt == item_goal) begin
                motor_drive = 1'b0;
                disp_st     = ST_DONE;
              end else begin
                motor_drive = 1'b1;
              end
            end
          end
        end
      end
      KIND_START: begin
        if (disp_st == ST_DISPENSING) begin
          starts_refused++;
        end else begin
          disp_st     = ST_DISPENSING;
          item_goal   = it.target_count;
          item_cnt    = '0;
          motor_drive = 1'b1;
          r.ack       = 1'b1;
        end
      end
      default: ;
    endcase
    r.motor_run     = motor_drive;
    r.status        = disp_st;
    r.items_counted = item_cnt;
    return r;
  endfunction

  function automatic item_t mk_item(input logic [KIND_W-1:0] k, input logic [SAMPLE_W-1:0] s0,
                                    input logic [SAMPLE_W-1:0] s1, input logic [SAMPLE_W-1:0] s2,
                                    input logic [SAMPLE_W-1:0] s3, input logic [COUNT_W-1:0] t);
    item_t it;
    it.kind         = k;
    it.ch0_sample   = s0;
    it.ch1_sample   = s1;
    it.ch2_sample   = s2;
    it.ch3_sample   = s3;
    it.target_count = t;
    return it;
  endfunction

  function automatic result_t mk_result(input logic mr, input logic det,
                                        input logic [CH_W-1:0] ch, input logic up,
                                        input logic ak, input logic mot, input status_e st,
                                        input logic [COUNT_W-1:0] cnt);
    result_t r;
    r.mean_ready     = mr;
    r.detected       = det;
    r.detect_channel = ch;
    r.detect_high    = up;
    r.ack            = ak;
    r.motor_run      = mot;
    r.status         = st;
    r.items_counted  = cnt;
    return r;
  endfunction

  // Well-formed sensor frame: baseline plus small noise, with a per-window
  // offset that pushes channels to either side of their windows.
  function automatic item_t sensor_frame();
    item_t               it;
    int                  v;
    int                  jig;
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    if (acc_frames == '0) begin
      for (int c = 0; c < NUM_CH; c++) begin
        jig = int'($urandom_range(0, 6)) - 2;
        if (soak_on) begin
          stim_offset[c] = (c == 0) ? 300 : 0;
        end else if (cfg_capture) begin
          stim_offset[c] = 0;
        end else begin
          case ($urandom_range(0, 9))
            6:       stim_offset[c] = int'(cfg_hi) + jig;
            7:       stim_offset[c] = -(int'(cfg_lo) + jig);
            8:       stim_offset[c] = -(int'(cfg_hi) + jig);
            9:       stim_offset[c] = int'($urandom_range(0, 8190)) - 4095;
            default: stim_offset[c] = 0;
          endcase
        end
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      v = stim_level[c] + stim_offset[c] + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
      smp[c] = 12'(v);
    end
    it = mk_item(KIND_SAMPLE, smp[0], smp[1], smp[2], smp[3], 8'($urandom_range(0, 255)));
    return it;
  endfunction

  // Mostly well-formed frames; the rest are commands, queries and raw noise.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    it = mk_item(KIND_SAMPLE, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.kind = KIND_START;
      case ($urandom_range(0, 9))
        0:       it.target_count = '0;
        1:       it.target_count = TARGET_MAX;
        2:       it.target_count = 8'($urandom_range(0, 255));
        default: it.target_count = 8'($urandom_range(1, 4));
      endcase
    end else if (pick < 9) begin
      it.kind = KIND_QUERY;
    end else if (pick < 11) begin
      it.kind = KIND_RESERVED;
    end else if (pick >= 19) begin
      it = sensor_frame();
    end
    return it;
  endfunction

  function automatic int pick_level(input int unsigned lvl_mode);
    int unsigned m;
    m = (lvl_mode == LVL_MIXED) ? $urandom_range(LVL_ANY, LVL_CEIL) : lvl_mode;
    case (m)
      LVL_FLOOR: return int'($urandom_range(0, 12));
      LVL_CEIL:  return int'($urandom_range(4083, 4095));
      default:   return int'($urandom_range(0, 4095));
    endcase
  endfunction

  // Offer one transaction, honouring the burst/gap pattern, and hold until
  // accepted. Returns at the accepting edge.
  task automatic push_item(input item_t it, input bit typed, input result_t want);
    result_t     model_res;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    // ready is stable by the falling edge; the transaction lands on the next rise
    do @(negedge clk_i); while (!item_if.ready);
    @(posedge clk_i);
    model_res = next_dispense_result(it);
    pending_results.push_back(typed ? want : model_res);
    items_sent++;
  endtask

  // Drop valid, let the block drain, then write all three registers over APB.
  task automatic settle_and_configure(input logic [MARGIN_W-1:0] hi,
                                      input logic [MARGIN_W-1:0] lo, input logic cap);
    logic [REG_IDX_W-1:0] idx [3];
    logic [PDATA_W-1:0]   val [3];
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    idx[0] = REG_HIGH_MARGIN;
    idx[1] = REG_LOW_MARGIN;
    idx[2] = REG_CAPTURE_MODE;
    val[0] = PDATA_W'(hi);
    val[1] = PDATA_W'(lo);
    val[2] = PDATA_W'(cap);
    for (int k = 0; k < 3; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[k], 2'b00};
      pwdata  <= val[k];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(negedge clk_i); while (!pready);
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_hi      = hi;
    cfg_lo      = lo;
    cfg_capture = cap;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: typed expectations only where they are obvious.
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t       stim;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } stim_row_t;

  stim_row_t dir_tab [7];

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [MARGIN_W-1:0] ph_hi;
    logic [MARGIN_W-1:0] ph_lo;
    int unsigned         lvl_mode;

    // Hold every input at a known value from time zero
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;

    // Predictor starts from the reset state
    for (int c = 0; c < NUM_CH; c++) begin
      acc_sum[c]     = '0;
      mean_ref[c]    = '0;
      stim_level[c]  = 2048;
      stim_offset[c] = 0;
    end
    acc_frames      = '0;
    disp_st         = ST_WAITING;
    item_cnt        = '0;
    item_goal       = '0;
    motor_drive     = 1'b0;
    cfg_hi          = HIGH_MARGIN_RST;
    cfg_lo          = LOW_MARGIN_RST;
    cfg_capture     = CAPTURE_MODE_RST;
    soak_on         = 1'b0;
    burst_left      = 0;
    items_sent      = 0;
    means_seen      = 0;
    detects_seen    = 0;
    starts_refused  = 0;

    // Query and reserved code straight after reset, a start, a refused
    // start, then one capture window built from full-scale and zero samples.
    dir_tab[0] = '{mk_item(KIND_QUERY, '0, '0, '0, '0, '0), 1, 1'b1,
                   mk_result(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, ST_WAITING, '0)};
    dir_tab[1] = '{mk_item(KIND_RESERVED, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                           TARGET_MAX), 1, 1'b1,
                   mk_result(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, ST_WAITING, '0)};
    dir_tab[2] = '{mk_item(KIND_START, '0, '0, '0, '0, TARGET_MAX), 1, 1'b1,
                   mk_result(1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b1, ST_DISPENSING, '0)};
    dir_tab[3] = '{mk_item(KIND_START, SAMPLE_MAX, '0, SAMPLE_MAX, '0, '0), 1, 1'b1,
                   mk_result(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1, ST_DISPENSING, '0)};
    dir_tab[4] = '{mk_item(KIND_SAMPLE, SAMPLE_MAX, '0, SAMPLE_MAX, '0, TARGET_MAX), 10,
                   1'b0, '0};
    dir_tab[5] = '{mk_item(KIND_SAMPLE, '0, SAMPLE_MAX, SAMPLE_MAX, '0, '0), 10, 1'b0, '0};
    dir_tab[6] = '{mk_item(KIND_QUERY, '0, '0, '0, '0, '0), 1, 1'b0, '0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      repeat (dir_tab[r].reps) push_item(dir_tab[r].stim, dir_tab[r].typed, dir_tab[r].want);
    end

    // Random phases: capture a fresh baseline, then watch for deviations
    // under a new pair of margins, extremes first.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       begin ph_hi = '0;         ph_lo = '0;         lvl_mode = LVL_ANY;   end
        1:       begin ph_hi = SAMPLE_MAX; ph_lo = SAMPLE_MAX; lvl_mode = LVL_ANY;   end
        2:       begin ph_hi = 12'd9;      ph_lo = 12'd9;      lvl_mode = LVL_FLOOR; end
        3:       begin ph_hi = 12'd5;      ph_lo = 12'd40;     lvl_mode = LVL_CEIL;  end
        4:       begin ph_hi = 12'd30;     ph_lo = 12'd2;      lvl_mode = LVL_MIXED; end
        5: begin
          ph_hi    = 12'($urandom_range(0, 64));
          ph_lo    = 12'($urandom_range(0, 64));
          lvl_mode = LVL_ANY;
        end
        default: begin
          ph_hi    = 12'($urandom_range(0, 4095));
          ph_lo    = 12'($urandom_range(0, 4095));
          lvl_mode = LVL_MIXED;
        end
      endcase
      for (int c = 0; c < NUM_CH; c++) stim_level[c] = pick_level(lvl_mode);

      settle_and_configure(cfg_hi, cfg_lo, 1'b1);
      repeat (2 * FRAMES_PER_MEAN) push_item(sensor_frame(), 1'b0, '0);
      settle_and_configure(ph_hi, ph_lo, 1'b0);
      repeat (PHASE_ITEMS) push_item(random_item(), 1'b0, '0);
    end

    // Short run to completion: zero margins, every mean deviates high on
    // channel 0, so a small target is reached within a few windows.
    for (int c = 0; c < NUM_CH; c++) stim_level[c] = 2000;
    settle_and_configure('0, '0, 1'b1);
    repeat (2 * FRAMES_PER_MEAN) push_item(sensor_frame(), 1'b0, '0);
    settle_and_configure('0, '0, 1'b0);
    soak_on = 1'b1;
    push_item(mk_item(KIND_START, '0, '0, '0, '0, 8'd3), 1'b0, '0);
    repeat (4 * FRAMES_PER_MEAN) push_item(sensor_frame(), 1'b0, '0);
    push_item(mk_item(KIND_QUERY, '0, '0, '0, '0, '0), 1'b0, '0);

    // Drain the pending results and let the pipeline settle
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d results: %0d means, %0d detections,",
             items_sent, results_checked, means_seen, detects_seen);
    $display("  %0d refused starts, %0d mismatches", starts_refused, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: back-pressure switches at random among free, coin-toss, sparse and bursty modes.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned tick;
    int unsigned mode;
    int unsigned hold;
    tick            = 0;
    mode            = SINK_FREE;
    hold            = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 300 == 0) mode = $urandom_range(SINK_FREE, SINK_BURSTY);
      case (mode)
        SINK_FREE:   result_if.ready <= 1'b1;
        SINK_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: result_if.ready <= (tick % 4 == 0);
        default: begin
          if (hold != 0) begin
            hold--;
            result_if.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 8);
            result_if.ready <= 1'b0;
          end else begin
            result_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: sample on the falling edge, so the transaction seen here is the
  // one that completes on the next rising edge.
  // ---------------------------------------------------------------------------
  initial begin
    results_checked = 0;
    mismatch_cnt    = 0;
  end

  always @(negedge clk_i) begin : result_check
    result_t want;
    result_t got;
    string   diffs;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got = result_if.payload;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_CAP)
          $display("%0t: result %h arrived with none expected", $time, got);
      end else begin
        want  = pending_results.pop_front();
        diffs = "";
        if (got.mean_ready !== want.mean_ready)
          diffs = {diffs, $sformatf(" mean_ready exp %0d act %0d",
                                    want.mean_ready, got.mean_ready)};
        if (got.detected !== want.detected)
          diffs = {diffs, $sformatf(" detected exp %0d act %0d", want.detected, got.detected)};
        if (got.detect_channel !== want.detect_channel)
          diffs = {diffs, $sformatf(" detect_channel exp %0d act %0d",
                                    want.detect_channel, got.detect_channel)};
        if (got.detect_high !== want.detect_high)
          diffs = {diffs, $sformatf(" detect_high exp %0d act %0d",
                                    want.detect_high, got.detect_high)};
        if (got.ack !== want.ack)
          diffs = {diffs, $sformatf(" ack exp %0d act %0d", want.ack, got.ack)};
        if (got.motor_run !== want.motor_run)
          diffs = {diffs, $sformatf(" motor_run exp %0d act %0d", want.motor_run, got.motor_run)};
        if (got.status !== want.status)
          diffs = {diffs, $sformatf(" status exp %0d act %0d", want.status, got.status)};
        if (got.items_counted !== want.items_counted)
          diffs = {diffs, $sformatf(" items_counted exp %0d act %0d",
                                    want.items_counted, got.items_counted)};
        if (diffs != "") begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_CAP)
            $display("%0t: result %0d differs:%s", $time, results_checked, diffs);
        end
      end
    end
  end

  // Watchdog: abandon the run if it overruns the cycle budget
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
